@@ hw/rtl/lcd_pkg.sv @@
package lcd_pkg;

    localparam int LEN_BITS   = 20;
    localparam int ZONE_BITS  = 17;
    localparam int TIME_BITS  = 32;
    localparam int TMO_BITS   = 16;
    localparam int ADDR_BITS  = 4;
    localparam int APB_BITS   = 32;

    localparam int POS_BITS_DEFAULT    = 21;
    localparam int ZONE_MAX_MM_DEFAULT = 5000;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // floor(x / 10) for x < 2**20 as (x * ceil(2**23 / 10)) >> 23
    localparam logic [LEN_BITS-1:0] DIV10_MULT  = 20'd838861;
    localparam int                  DIV10_SHIFT = 23;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_PATH_LEN = 2'd0;
    localparam logic [1:0] REG_PATH_OK  = 2'd1;
    localparam logic [1:0] REG_FRESH    = 2'd2;
    localparam logic [1:0] REG_COOLDOWN = 2'd3;

    localparam logic [TMO_BITS-1:0] FRESH_TIMEOUT_RESET = 16'd1000;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_TICK   = 1'b1;

    typedef struct packed {
        logic [LEN_BITS-1:0]  path_len;
        logic                 path_ok;
        logic [ZONE_BITS-1:0] zone;
        logic [TMO_BITS-1:0]  fresh_timeout;
        logic [TMO_BITS-1:0]  cooldown;
    } lcd_cfg_t;

    typedef struct packed {
        logic tick;
        logic rejected;
        logic cur_mid;
        logic cur_start;
    } lcd_class_t;

endpackage

@@ hw/rtl/lap_crossing_detector.sv @@
// lap counter for a vehicle on a closed path
//
// input stream: one request per position sample or time tick. s_tuser is the
// action (0 sample, 1 tick), s_tdata carries position and timestamp. every
// request gives exactly one result on the output stream: lap flag, armed flag
// and tracking flag after the request.
// apb port: path length, path valid, freshness timeout and cooldown. the user
// must write them only while the block is idle; the block does not enforce it.
// the seam zone is registered from the length, in the cycle after a write.
// each request passes the input register, then a queue slot, then the result
// register. throughput: one request per cycle while the receiver takes
// results; the back end updates its state as it pops each request.
// a four-entry queue parts the classifying front end from the state update,
// so a stalled receiver first fills the result register, then the queue and
// the input register, and only then drops s_tready. nothing is lost or
// repeated under backpressure.
// reset: clears tracking, armed and lap-time state, empties the queue and
// loads register defaults (length 0, path not valid, timeout 1000 ms,
// cooldown 0).
module lap_crossing_detector
    import lcd_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEFAULT,
    parameter int ZONE_MAX_MM = ZONE_MAX_MM_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // position_mm, time_ms, zero padding to whole bytes
    input  logic [((POS_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  logic                      s_tuser,
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // lap_counted, is_armed, is_tracking, zero padding
    output logic [7:0]                m_tdata,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_BITS-1:0]      paddr,
    input  logic [APB_BITS-1:0]       pwdata,
    output logic [APB_BITS-1:0]       prdata,
    output logic                      pready
);

    // queue entry: class flags, position, timestamp
    localparam int ENTRY_W = $bits(lcd_class_t) + POS_BITS + TIME_BITS;

    lcd_cfg_t              cfg;
    logic                  q_push;
    logic                  q_not_full;
    logic                  q_pop;
    logic                  q_not_empty;
    lcd_class_t            f_class;
    logic [POS_BITS-1:0]   f_pos;
    logic [TIME_BITS-1:0]  f_time;
    lcd_class_t            b_class;
    logic [POS_BITS-1:0]   b_pos;
    logic [TIME_BITS-1:0]  b_time;
    logic [ENTRY_W-1:0]    push_entry;
    logic [ENTRY_W-1:0]    pop_entry;

    // register file and seam zone
    lcd_cfg #(
        .ZONE_MAX_MM (ZONE_MAX_MM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end: register the request and classify the position
    lcd_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_class  (f_class),
        .q_pos    (f_pos),
        .q_time   (f_time)
    );

    assign push_entry = {f_class, f_pos, f_time};

    lcd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH_DEFAULT)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_entry)
    );

    assign {b_class, b_pos, b_time} = pop_entry;

    // back end: staleness, arming, lap count and result register
    lcd_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_not_empty),
        .q_pop    (q_pop),
        .q_class  (b_class),
        .q_pos    (b_pos),
        .q_time   (b_time),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/lcd_cfg.sv @@
module lcd_cfg
    import lcd_pkg::*;
#(
    parameter int ZONE_MAX_MM = ZONE_MAX_MM_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [APB_BITS-1:0]  pwdata,
    output logic [APB_BITS-1:0]  prdata,
    output logic                 pready,
    output lcd_cfg_t             cfg
);

    localparam logic [ZONE_BITS-1:0] ZONE_CAP = ZONE_BITS'(ZONE_MAX_MM);

    logic [LEN_BITS-1:0]    path_len_reg;
    logic                   path_ok_reg;
    logic [TMO_BITS-1:0]    fresh_reg;
    logic [TMO_BITS-1:0]    cooldown_reg;
    logic [ZONE_BITS-1:0]   zone_reg;
    logic [ZONE_BITS-1:0]   zone_next;
    logic [2*LEN_BITS-1:0]  div_prod;
    logic [ZONE_BITS-1:0]   zone_raw;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_len_reg <= '0;
            path_ok_reg  <= 1'b0;
            fresh_reg    <= FRESH_TIMEOUT_RESET;
            cooldown_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_PATH_LEN: path_len_reg <= pwdata[LEN_BITS-1:0];
                REG_PATH_OK:  path_ok_reg  <= pwdata[0];
                REG_FRESH:    fresh_reg    <= pwdata[TMO_BITS-1:0];
                REG_COOLDOWN: cooldown_reg <= pwdata[TMO_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // seam zone, registered from the length in the cycle after it changes
    assign div_prod  = path_len_reg * DIV10_MULT;
    assign zone_raw  = div_prod[DIV10_SHIFT+ZONE_BITS-1:DIV10_SHIFT];
    assign zone_next = (zone_raw > ZONE_CAP) ? ZONE_CAP : zone_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
        end
        else
        begin
            zone_reg <= zone_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PATH_LEN: prdata = APB_BITS'(path_len_reg);
            REG_PATH_OK:  prdata = APB_BITS'(path_ok_reg);
            REG_FRESH:    prdata = APB_BITS'(fresh_reg);
            REG_COOLDOWN: prdata = APB_BITS'(cooldown_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.path_len      = path_len_reg;
    assign cfg.path_ok       = path_ok_reg;
    assign cfg.zone          = zone_reg;
    assign cfg.fresh_timeout = fresh_reg;
    assign cfg.cooldown      = cooldown_reg;

endmodule

@@ hw/rtl/lcd_front.sv @@
module lcd_front
    import lcd_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((POS_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                      s_tuser,
    input  lcd_cfg_t                  cfg,
    input  logic                      q_ready,
    output logic                      q_push,
    output lcd_class_t                q_class,
    output logic [POS_BITS-1:0]       q_pos,
    output logic [TIME_BITS-1:0]      q_time
);

    localparam int CW = (POS_BITS - 1 > LEN_BITS) ? POS_BITS - 1 : LEN_BITS;

    logic                  s1_valid_reg;
    logic                  s1_tick_reg;
    logic [POS_BITS-1:0]   s1_pos_reg;
    logic [TIME_BITS-1:0]  s1_time_reg;
    logic                  load;
    logic                  neg;
    logic [CW-1:0]         mag;
    logic [CW-1:0]         len_x;
    logic [CW-1:0]         zone_x;
    logic [CW-1:0]         lim_x;
    logic [LEN_BITS-1:0]   lim_hi;

    assign s_tready = !s1_valid_reg || q_ready;
    assign load     = s_tvalid && s_tready;
    assign q_push   = s1_valid_reg && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_tick_reg <= s_tuser;
            s1_pos_reg  <= s_tdata[POS_BITS-1:0];
            s1_time_reg <= s_tdata[POS_BITS+TIME_BITS-1:POS_BITS];
        end
    end

    // position classes against the seam zones
    assign neg    = s1_pos_reg[POS_BITS-1];
    assign mag    = CW'(s1_pos_reg[POS_BITS-2:0]);
    assign lim_hi = cfg.path_len - LEN_BITS'(cfg.zone);
    assign len_x  = CW'(cfg.path_len);
    assign zone_x = CW'(cfg.zone);
    assign lim_x  = CW'(lim_hi);

    always_comb
    begin
        q_class.tick      = (s1_tick_reg == ACTION_TICK);
        q_class.rejected  = !cfg.path_ok || neg || (mag > len_x);
        q_class.cur_mid   = (mag > zone_x) && (mag < lim_x);
        q_class.cur_start = (mag <= zone_x);
    end

    assign q_pos  = s1_pos_reg;
    assign q_time = s1_time_reg;

endmodule

@@ hw/rtl/lcd_queue.sv @@
module lcd_queue
    import lcd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_CNT = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign not_full  = (count_reg != DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/lcd_back.sv @@
module lcd_back
    import lcd_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcd_cfg_t              cfg,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  lcd_class_t            q_class,
    input  logic [POS_BITS-1:0]   q_pos,
    input  logic [TIME_BITS-1:0]  q_time,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata
);

    localparam int CW = (POS_BITS - 1 > LEN_BITS) ? POS_BITS - 1 : LEN_BITS;

    logic                  out_valid_reg;
    logic                  counted_reg;
    logic                  counted_next;
    logic                  armed_reg;
    logic                  armed_next;
    logic                  have_reg;
    logic                  have_next;
    logic                  have_cnt_reg;
    logic                  have_cnt_next;
    logic [TIME_BITS-1:0]  cnt_time_reg;
    logic [TIME_BITS-1:0]  cnt_time_next;
    logic [POS_BITS-1:0]   last_pos_reg;
    logic [TIME_BITS-1:0]  last_time_reg;
    logic                  update_sample;
    logic [TIME_BITS-1:0]  gap;
    logic [TIME_BITS-1:0]  since_cnt;
    logic                  stale;
    logic                  cool;
    logic                  move_back;
    logic                  move_fwd;
    logic [CW-1:0]         last_mag;
    logic [CW-1:0]         zone_x;
    logic [CW-1:0]         lim_x;
    logic [LEN_BITS-1:0]   lim_hi;
    logic                  prev_mid;
    logic                  prev_end;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    assign gap       = q_time - last_time_reg;
    assign since_cnt = q_time - cnt_time_reg;
    assign stale     = have_reg && ((q_time < last_time_reg) ||
                                    (gap > TIME_BITS'(cfg.fresh_timeout)));
    assign cool      = !have_cnt_reg || ((q_time >= cnt_time_reg) &&
                                         (since_cnt >= TIME_BITS'(cfg.cooldown)));
    assign move_back = $signed(q_pos) < $signed(last_pos_reg);
    assign move_fwd  = $signed(q_pos) > $signed(last_pos_reg);

    // held sample classed against the seam zones of the present path
    assign last_mag = CW'(last_pos_reg[POS_BITS-2:0]);
    assign lim_hi   = cfg.path_len - LEN_BITS'(cfg.zone);
    assign zone_x   = CW'(cfg.zone);
    assign lim_x    = CW'(lim_hi);
    assign prev_mid = (last_mag > zone_x) && (last_mag < lim_x);
    assign prev_end = (last_mag >= lim_x);

    always_comb
    begin
        counted_next  = 1'b0;
        armed_next    = armed_reg;
        have_next     = have_reg;
        have_cnt_next = have_cnt_reg;
        cnt_time_next = cnt_time_reg;
        update_sample = 1'b0;
        if (q_class.tick)
        begin
            if (stale)
            begin
                armed_next = 1'b0;
                have_next  = 1'b0;
            end
        end
        else if (q_class.rejected)
        begin
            armed_next = 1'b0;
            have_next  = 1'b0;
        end
        else
        begin
            update_sample = 1'b1;
            have_next     = 1'b1;
            if (stale)
            begin
                armed_next = 1'b0;
            end
            else if (have_reg)
            begin
                if (move_back)
                begin
                    if (prev_end && q_class.cur_start && armed_reg && cool)
                    begin
                        counted_next  = 1'b1;
                        have_cnt_next = 1'b1;
                        cnt_time_next = q_time;
                    end
                    armed_next = 1'b0;
                end
                else if (move_fwd && prev_mid && q_class.cur_mid)
                begin
                    armed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            counted_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            have_reg      <= 1'b0;
            have_cnt_reg  <= 1'b0;
            cnt_time_reg  <= '0;
            last_pos_reg  <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                counted_reg   <= counted_next;
                armed_reg     <= armed_next;
                have_reg      <= have_next;
                have_cnt_reg  <= have_cnt_next;
                cnt_time_reg  <= cnt_time_next;
                if (update_sample)
                begin
                    last_pos_reg  <= q_pos;
                    last_time_reg <= q_time;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, have_reg, armed_reg, counted_reg};

endmodule
